/* rtl/core/pfs_pkg.sv */
// ---------------------------------------------------------------------------
// pfs_pkg
// Shared types and codes of the page frame free stack.
// ---------------------------------------------------------------------------
package pfs_pkg;

	localparam int unsigned ADDR_W     = 32;
	localparam int unsigned STATUS_W   = 2;
	localparam int unsigned CFG_IDX_W  = 1;
	localparam int unsigned CFG_DATA_W = 32;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_BAD   = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_KERNEL_END = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PHYS_TOP   = 1'd1;

	localparam logic [ADDR_W-1:0] KERNEL_END_RST = 32'd0;
	localparam logic [ADDR_W-1:0] PHYS_TOP_RST   = 32'd234881024;

	typedef struct packed {
		logic push;
		logic pop;
	} pfs_op_t;

endpackage

/* rtl/core/page_frame_free_stack_core.sv */
// ---------------------------------------------------------------------------
// page_frame_free_stack_core
// Physical page allocator built as a last-in first-out stack of free frames.
// ---------------------------------------------------------------------------
// The input stream carries one request per transaction: tuser selects free
// (0) or allocate (1), tdata holds the page byte address of a free. A free
// of an aligned page in [kernel_end, phys_top) is pushed if there is room, an
// allocate pops the most recently freed page. Each request gives one result
// with the granted address, a status and the free page count after it.
// The cfg channel writes kernel_end (index 0) and phys_top (index 1); it is
// always ready. The user writes it only while no request is in flight; the
// block does not enforce this. A request passes one input register, then the
// check and stack update into the result register.
// Throughput is one request per cycle while results are accepted: the top and
// next-below frames sit in registers and the memory read of the frame below
// them is launched one pop ahead. A stalled receiver holds the result register
// and the input register, after which the input stream is held off.
// Reset empties the stack and loads the register defaults; no clearing
// pass is needed since only entries below the level are ever used.
// ---------------------------------------------------------------------------
module page_frame_free_stack_core #(
	parameter int unsigned MAX_PAGES  = 1024,
	parameter int unsigned PAGE_SHIFT = 12
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      s_axis_tvalid,
	output logic                                      s_axis_tready,
	input  logic [pfs_pkg::ADDR_W-1:0]                s_axis_tdata,  // page_address
	input  logic                                      s_axis_tuser,  // mode
	output logic                                      m_axis_tvalid,
	input  logic                                      m_axis_tready,
	// granted_address, status, free_count, zero pad
	output logic [((pfs_pkg::ADDR_W+pfs_pkg::STATUS_W+$clog2(MAX_PAGES+1)+7)/8)*8-1:0]
	                                                  m_axis_tdata,
	input  logic                                      cfg_valid,
	output logic                                      cfg_ready,
	input  logic [pfs_pkg::CFG_IDX_W-1:0]             cfg_index,
	input  logic [pfs_pkg::CFG_DATA_W-1:0]            cfg_data
);

	localparam int unsigned AW      = pfs_pkg::ADDR_W;
	localparam int unsigned LW      = $clog2(MAX_PAGES + 1);
	localparam int unsigned FRAME_W = AW - PAGE_SHIFT;
	localparam int unsigned OUT_W   = ((AW + pfs_pkg::STATUS_W + LW + 7) / 8) * 8;

	logic [AW-1:0] kernel_end_q;
	logic [AW-1:0] phys_top_q;

	logic          valid_s1;
	logic          mode_s1;
	logic [AW-1:0] addr_s1;

	logic                          out_valid_q;
	logic [AW-1:0]                 granted_q;
	logic [pfs_pkg::STATUS_W-1:0]  status_q;
	logic [LW-1:0]                 count_q;

	logic                          advance;
	logic                          page_ok;
	logic                          full;
	logic                          empty;
	pfs_pkg::pfs_op_t              op;
	logic [LW-1:0]                 level;
	logic [FRAME_W-1:0]            top_frame;
	logic [pfs_pkg::STATUS_W-1:0]  status;
	logic [AW-1:0]                 granted;
	logic [LW-1:0]                 next_level;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kernel_end_q <= pfs_pkg::KERNEL_END_RST;
			phys_top_q   <= pfs_pkg::PHYS_TOP_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				pfs_pkg::REG_KERNEL_END: kernel_end_q <= cfg_data;
				pfs_pkg::REG_PHYS_TOP:   phys_top_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			mode_s1 <= s_axis_tuser;
			addr_s1 <= s_axis_tdata;
		end
	end

	assign page_ok = (addr_s1[PAGE_SHIFT-1:0] == '0) && (addr_s1 >= kernel_end_q)
	                 && (addr_s1 < phys_top_q);
	assign full    = (level == LW'(MAX_PAGES));
	assign empty   = (level == '0);

	assign op.push = advance && !mode_s1 && page_ok && !full;
	assign op.pop  = advance && mode_s1 && !empty;

	always_comb begin
		status  = pfs_pkg::ST_OK;
		granted = '0;
		if (!mode_s1) begin
			if (!page_ok) begin
				status = pfs_pkg::ST_BAD;
			end else if (full) begin
				status = pfs_pkg::ST_FULL;
			end
		end else if (empty) begin
			status = pfs_pkg::ST_EMPTY;
		end else begin
			granted = {top_frame, {PAGE_SHIFT{1'b0}}};
		end
	end

	always_comb begin
		next_level = level;
		if (op.push) begin
			next_level = level + LW'(1);
		end else if (op.pop) begin
			next_level = level - LW'(1);
		end
	end

	pfs_stack #(
		.MAX_PAGES (MAX_PAGES),
		.FRAME_W   (FRAME_W)
	) u_stack (
		.clk        (clk),
		.arst_n     (arst_n),
		.op         (op),
		.push_frame (addr_s1[AW-1:PAGE_SHIFT]),
		.level      (level),
		.top_frame  (top_frame)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			granted_q <= granted;
			status_q  <= status;
			count_q   <= next_level;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_W'({count_q, status_q, granted_q});

	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		level <= LW'(MAX_PAGES))
		else $error("free page level above capacity");

	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		op.push |=> (level == $past(level) + LW'(1)))
		else $error("push did not raise the level");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (status_q == pfs_pkg::ST_FULL)) |-> (count_q == LW'(MAX_PAGES)))
		else $error("full status with room left");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (status_q == pfs_pkg::ST_EMPTY))
		|-> ((granted_q == '0) && (count_q == '0)))
		else $error("empty status with a page granted");

endmodule

/* rtl/core/pfs_stack.sv */
// ---------------------------------------------------------------------------
// pfs_stack
// Frame stack: top and next-below entries in registers, the rest in memory.
// ---------------------------------------------------------------------------
module pfs_stack #(
	parameter int unsigned MAX_PAGES = 1024,
	parameter int unsigned FRAME_W   = 20
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  pfs_pkg::pfs_op_t                     op,
	input  logic [FRAME_W-1:0]                   push_frame,
	output logic [$clog2(MAX_PAGES+1)-1:0]       level,
	output logic [FRAME_W-1:0]                   top_frame
);

	localparam int unsigned LW = $clog2(MAX_PAGES + 1);
	localparam int unsigned AW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;

	logic [FRAME_W-1:0] mem [MAX_PAGES];
	logic [FRAME_W-1:0] mem_rd_q;
	logic [FRAME_W-1:0] top_q;
	logic [FRAME_W-1:0] below_q;
	logic               sel_mem_q;
	logic [LW-1:0]      level_q;

	logic [FRAME_W-1:0] below;
	logic [LW-1:0]      wr_lvl;
	logic [LW-1:0]      rd_lvl;
	logic [AW-1:0]      wr_addr;
	logic [AW-1:0]      rd_addr;

	assign below   = sel_mem_q ? mem_rd_q : below_q;
	assign wr_lvl  = level_q - LW'(1);
	assign rd_lvl  = level_q - LW'(3);
	assign wr_addr = wr_lvl[AW-1:0];
	assign rd_addr = rd_lvl[AW-1:0];

	// entries below the next-below one live in memory
	always_ff @(posedge clk) begin
		if (op.push && (level_q != '0)) begin
			mem[wr_addr] <= top_q;
		end
		mem_rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (op.push) begin
			top_q   <= push_frame;
			below_q <= top_q;
		end else if (op.pop) begin
			top_q <= below;
		end else begin
			below_q <= below;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q   <= '0;
			sel_mem_q <= 1'b0;
		end else begin
			sel_mem_q <= op.pop;
			if (op.push) begin
				level_q <= level_q + LW'(1);
			end else if (op.pop) begin
				level_q <= level_q - LW'(1);
			end
		end
	end

	assign level     = level_q;
	assign top_frame = top_q;

endmodule
